### rtl/gwsp_pkg.sv
package gwsp_pkg;

    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 32;
    localparam int MAX_WORD = 16;

    localparam int DIM_W   = 6;
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ADDR_W  = $clog2(MAX_ROWS * MAX_COLS);
    localparam int K_W     = $clog2(MAX_WORD);
    localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd1;

    typedef enum logic [1:0] {
        REQ_GRID_WR = 2'd0,
        REQ_WORD_WR = 2'd1,
        REQ_PROBE   = 2'd2
    } req_t;

    typedef struct packed {
        logic grid_wr;
        logic word_wr;
        logic load;
        logic step;
        logic publish;
    } gwsp_cmd_t;

    typedef struct packed {
        logic last;
    } gwsp_sts_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

### rtl/gwsp_ctrl.sv
module gwsp_ctrl
    import gwsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_req_type,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output gwsp_cmd_t  cmd,
    input  gwsp_sts_t  sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   s_beat;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_beat  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    cmd.grid_wr = (s_req_type == REQ_GRID_WR);
                    cmd.word_wr = (s_req_type == REQ_WORD_WR);
                    cmd.load    = (s_req_type == REQ_PROBE);
                    if (s_req_type == REQ_PROBE) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (sts.last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/gwsp_dp.sv
module gwsp_dp
    import gwsp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_wdata,
    input  logic [4:0]           s_cell_row,
    input  logic [4:0]           s_cell_col,
    input  logic [7:0]           s_cell_char,
    input  logic [3:0]           s_word_index,
    input  logic [7:0]           s_word_char,
    input  logic [4:0]           s_word_length,
    output logic                 m_horiz_match,
    output logic                 m_vert_match,
    input  gwsp_cmd_t            cmd,
    output gwsp_sts_t            sts
);

    logic [7:0] grid_mem [GRID_DEPTH];
    logic [7:0] word_mem [MAX_WORD];

    logic [DIM_W-1:0] rows_reg, cols_reg;
    logic [DIM_W-1:0] rows_eff, cols_eff;
    logic [4:0]       row_reg, col_reg;
    logic [K_W-1:0]   len_m1_reg;
    logic [K_W-1:0]   k_reg;
    logic             dir_reg;
    logic             h_ok_reg, v_ok_reg;
    logic             rd_pend_reg, rd_dir_reg;
    logic [7:0]       grid_q_reg, word_q_reg;
    logic             h_out_reg, v_out_reg;

    logic [DIM_W-1:0]  r_pos, c_pos;
    logic              in_bounds;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic              grid_wr_ok, word_wr_ok;
    logic              probe_ok;
    logic              char_ok;
    logic              h_ok_now, v_ok_now;

    assign rows_eff = (int'(rows_reg) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : rows_reg;
    assign cols_eff = (int'(cols_reg) > MAX_COLS) ? DIM_W'(MAX_COLS) : cols_reg;

    assign r_pos = DIM_W'(row_reg) + (dir_reg ? DIM_W'(k_reg) : DIM_W'(0));
    assign c_pos = DIM_W'(col_reg) + (dir_reg ? DIM_W'(0) : DIM_W'(k_reg));
    assign in_bounds = (r_pos < rows_eff) && (c_pos < cols_eff);
    assign rd_addr = ADDR_W'(int'(r_pos[ROW_W-1:0]) * MAX_COLS + int'(c_pos[COL_W-1:0]));

    assign grid_wr_ok = (int'(s_cell_row) < MAX_ROWS) && (int'(s_cell_col) < MAX_COLS);
    assign word_wr_ok = (int'(s_word_index) < MAX_WORD);
    assign wr_addr = ADDR_W'(int'(s_cell_row) * MAX_COLS + int'(s_cell_col));

    assign probe_ok = (s_word_length != 5'd0) && (int'(s_word_length) <= MAX_WORD)
                   && (DIM_W'(s_cell_row) < rows_eff) && (DIM_W'(s_cell_col) < cols_eff);

    assign char_ok = is_letter(grid_q_reg) && (grid_q_reg == word_q_reg);

    // fold in the compare still in flight when the result is published
    assign h_ok_now = h_ok_reg && !(rd_pend_reg && !rd_dir_reg && !char_ok);
    assign v_ok_now = v_ok_reg && !(rd_pend_reg && rd_dir_reg && !char_ok);

    assign sts.last = dir_reg && (k_reg == len_m1_reg);

    assign m_horiz_match = h_out_reg;
    assign m_vert_match  = v_out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.grid_wr && grid_wr_ok) begin
            grid_mem[wr_addr] <= s_cell_char;
        end
        grid_q_reg <= grid_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.word_wr && word_wr_ok) begin
            word_mem[s_word_index[K_W-1:0]] <= s_word_char;
        end
        word_q_reg <= word_mem[k_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= '0;
            cols_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_GRID_ROWS: rows_reg <= cfg_wdata;
                CFG_GRID_COLS: cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // scan: one read per cycle, compare lands in the following cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            dir_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
            rd_dir_reg  <= 1'b0;
            h_ok_reg    <= 1'b0;
            v_ok_reg    <= 1'b0;
            len_m1_reg  <= '0;
        end else begin
            rd_pend_reg <= 1'b0;
            if (cmd.load) begin
                row_reg    <= s_cell_row;
                col_reg    <= s_cell_col;
                len_m1_reg <= probe_ok ? K_W'(s_word_length - 5'd1) : '0;
                k_reg      <= '0;
                dir_reg    <= 1'b0;
                h_ok_reg   <= probe_ok;
                v_ok_reg   <= probe_ok;
            end else begin
                if (cmd.step) begin
                    rd_pend_reg <= in_bounds;
                    rd_dir_reg  <= dir_reg;
                    if (!in_bounds) begin
                        if (dir_reg) begin
                            v_ok_reg <= 1'b0;
                        end else begin
                            h_ok_reg <= 1'b0;
                        end
                    end
                    if (k_reg == len_m1_reg) begin
                        k_reg   <= '0;
                        dir_reg <= 1'b1;
                    end else begin
                        k_reg <= k_reg + K_W'(1);
                    end
                end
                if (rd_pend_reg && !char_ok) begin
                    if (rd_dir_reg) begin
                        v_ok_reg <= 1'b0;
                    end else begin
                        h_ok_reg <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            h_out_reg <= h_ok_now;
            v_out_reg <= v_ok_now;
        end
    end

endmodule

### rtl/grid_word_search_probe.sv
// Grid writes, word writes and unused request codes: accepted with no result beat.
// Probe: one grid memory read per cycle for each of the L word positions, rightward
// then downward (one position for an invalid probe), then the result beat.
// One probe at a time: no new request is taken until its result is published.
// Reset (aresetn, synchronous, active low) clears control and config registers;
// grid and word stores are not cleared.
module grid_word_search_probe
    import gwsp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_req_type,
    input  logic [4:0]           s_cell_row,
    input  logic [4:0]           s_cell_col,
    input  logic [7:0]           s_cell_char,
    input  logic [3:0]           s_word_index,
    input  logic [7:0]           s_word_char,
    input  logic [4:0]           s_word_length,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_horiz_match,
    output logic                 m_vert_match
);

    gwsp_cmd_t cmd;
    gwsp_sts_t sts;

    gwsp_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    gwsp_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_cell_row    (s_cell_row),
        .s_cell_col    (s_cell_col),
        .s_cell_char   (s_cell_char),
        .s_word_index  (s_word_index),
        .s_word_char   (s_word_char),
        .s_word_length (s_word_length),
        .m_horiz_match (m_horiz_match),
        .m_vert_match  (m_vert_match),
        .cmd           (cmd),
        .sts           (sts)
    );

    a_busy_after_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_ready)
        else $error("input taken while a probe is in flight");

    a_publish_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> m_valid)
        else $error("result beat not presented after publish");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.grid_wr, cmd.word_wr, cmd.load, cmd.step, cmd.publish}))
        else $error("more than one datapath command in a cycle");

    a_no_publish_over_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !cmd.publish)
        else $error("result overwritten before it was taken");

endmodule
